[design/sldf_pkg.sv]
package sldf_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_VALUE = 2'd0;
    localparam logic [1:0] CFG_CRC_POLY   = 2'd1;
    localparam logic [1:0] CFG_CRC_INIT   = 2'd2;

    // Frame status codes.
    localparam logic ST_GOOD    = 1'b0;
    localparam logic ST_CRC_ERR = 1'b1;

    // Length width in a descriptor, wide enough for the largest supported payload.
    localparam int DLEN_W = 7;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] crc_polynomial;
        logic [7:0] crc_initial;
    } t_cfg;

    // One finished frame, handed from the parser to the drain side.
    typedef struct packed {
        logic              status;
        logic [7:0]        command;
        logic [DLEN_W-1:0] length;
        logic [31:0]       good_count;
        logic [31:0]       err_count;
        logic              bank;
    } t_desc;

    typedef struct packed {
        logic        frame_status;
        logic [7:0]  command;
        logic [5:0]  payload_length;
        logic [7:0]  payload_byte;
        logic [4:0]  byte_index;
        logic        last;
        logic [31:0] good_frame_count;
        logic [31:0] crc_error_count;
    } t_result;

    // One byte through the CRC-8 register, MSB first, no final XOR.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/sldf_pbuf.sv]
module sldf_pbuf #(
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [2**ADDR_W];
    logic [7:0] r_q;

    // Write port, fed by the parser.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, fed by the drain side.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[design/sldf_dq.sv]
module sldf_dq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sldf_pkg::t_desc  i_desc,
    input  logic             i_pop,
    output sldf_pkg::t_desc  o_head,
    output logic             o_empty,
    output logic             o_full
);
    import sldf_pkg::*;

    t_desc      r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_head  = r_slot[r_rptr];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    // Occupancy after this cycle's push and pop.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Pointer and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // Descriptor storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_desc;
        end
    end

endmodule

[design/sldf_front.sv]
module sldf_front #(
    parameter int MAX_PAYLOAD = 32,
    parameter int IDX_W       = 5,
    parameter int LEN_W       = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  sldf_pkg::t_cfg      i_cfg,
    output logic                o_push,
    output sldf_pkg::t_desc     o_desc,
    output logic                o_we,
    output logic [IDX_W:0]      o_waddr,
    output logic [7:0]          o_wdata
);
    import sldf_pkg::*;

    localparam logic [2:0] PH_SYNC    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_CMD     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC     = 3'd4;

    localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_PAYLOAD);

    logic [2:0]       r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_crc, n_crc;
    logic [31:0]      r_good, n_good;
    logic [31:0]      r_bad, n_bad;
    logic             r_bank, n_bank;
    logic [LEN_W-1:0] pos_inc;
    logic             crc_ok;

    assign pos_inc = r_pos + LEN_W'(1);
    assign crc_ok  = (r_crc == i_byte);

    // Parser: one byte per transfer, frame results pushed as a descriptor.
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_pos   = r_pos;
        n_cmd   = r_cmd;
        n_crc   = r_crc;
        n_good  = r_good;
        n_bad   = r_bad;
        n_bank  = r_bank;
        o_push  = 1'b0;
        o_we    = 1'b0;
        if (i_accept) begin
            case (r_phase)
                PH_LEN: begin
                    if (i_byte > MAX_LEN_BYTE) begin
                        n_phase = PH_SYNC;
                    end else begin
                        n_len   = LEN_W'(i_byte);
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_cmd   = i_byte;
                    n_pos   = '0;
                    n_crc   = crc8_byte(i_cfg.crc_initial, i_byte, i_cfg.crc_polynomial);
                    n_phase = (r_len == '0) ? PH_CRC : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_we  = 1'b1;
                    n_pos = pos_inc;
                    n_crc = crc8_byte(r_crc, i_byte, i_cfg.crc_polynomial);
                    if (pos_inc >= r_len) begin
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    o_push  = 1'b1;
                    n_bank  = ~r_bank;
                    n_phase = PH_SYNC;
                    if (crc_ok) begin
                        n_good = r_good + 32'd1;
                    end else begin
                        n_bad = r_bad + 32'd1;
                    end
                end
                default: begin
                    n_phase = (i_byte == i_cfg.sync_value) ? PH_LEN : PH_SYNC;
                end
            endcase
        end
    end

    // Descriptor and payload buffer write.
    always_comb begin
        o_desc.status     = crc_ok ? ST_GOOD : ST_CRC_ERR;
        o_desc.command    = r_cmd;
        o_desc.length     = DLEN_W'(r_len);
        o_desc.good_count = n_good;
        o_desc.err_count  = n_bad;
        o_desc.bank       = r_bank;
        o_waddr           = {r_bank, r_pos[IDX_W-1:0]};
        o_wdata           = i_byte;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_len   <= '0;
            r_pos   <= '0;
            r_cmd   <= 8'd0;
            r_crc   <= 8'd0;
            r_good  <= 32'd0;
            r_bad   <= 32'd0;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_cmd   <= n_cmd;
            r_crc   <= n_crc;
            r_good  <= n_good;
            r_bad   <= n_bad;
            r_bank  <= n_bank;
        end
    end

endmodule

[design/sldf_back.sv]
module sldf_back #(
    parameter int IDX_W = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sldf_pkg::t_desc     i_head,
    input  logic                i_desc_empty,
    output logic                o_desc_pop,
    output logic                o_re,
    output logic [IDX_W:0]      o_raddr,
    input  logic [7:0]          i_rdata,
    input  logic                i_pop,
    output logic                o_empty,
    output sldf_pkg::t_result   o_result
);
    import sldf_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_s1_valid;
    t_result          r_s1;
    logic             r_s1_zero;
    t_result          r_out [2];
    logic             r_owr;
    logic             r_ord;
    logic [1:0]       r_ocnt;
    logic [1:0]       n_ocnt;
    logic             pop_fire;
    logic [2:0]       room_use;
    logic             issue;
    logic             zero_item;
    logic             last_item;
    t_result          s1_next;
    t_result          s2_item;

    assign pop_fire  = i_pop && (r_ocnt != 2'd0);
    assign room_use  = 3'(r_ocnt) + 3'(r_s1_valid) - 3'(pop_fire);
    assign issue     = !i_desc_empty && (room_use < 3'd2);
    assign zero_item = (i_head.status == ST_CRC_ERR) || (i_head.length == '0);
    assign last_item = zero_item || ((DLEN_W'(r_idx) + DLEN_W'(1)) == i_head.length);

    assign o_desc_pop = issue && last_item;
    assign o_re       = issue;
    assign o_raddr    = {i_head.bank, r_idx};
    assign o_empty    = (r_ocnt == 2'd0);
    assign o_result   = r_out[r_ord];

    // Result fields for the item being issued; the byte arrives from the buffer in the next cycle.
    always_comb begin
        s1_next.frame_status     = i_head.status;
        s1_next.command          = i_head.command;
        s1_next.payload_length   = 6'(i_head.length);
        s1_next.payload_byte     = 8'd0;
        s1_next.byte_index       = zero_item ? 5'd0 : 5'(r_idx);
        s1_next.last             = last_item;
        s1_next.good_frame_count = i_head.good_count;
        s1_next.crc_error_count  = i_head.err_count;
    end

    // Merge the buffer read data into the item.
    always_comb begin
        s2_item              = r_s1;
        s2_item.payload_byte = r_s1_zero ? 8'd0 : i_rdata;
    end

    // Output queue occupancy.
    always_comb begin
        n_ocnt = r_ocnt;
        if (r_s1_valid && !pop_fire) begin
            n_ocnt = r_ocnt + 2'd1;
        end else if (!r_s1_valid && pop_fire) begin
            n_ocnt = r_ocnt - 2'd1;
        end
    end

    // Drain control: byte position, read stage and output queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_owr      <= 1'b0;
            r_ord      <= 1'b0;
            r_ocnt     <= 2'd0;
        end else begin
            r_s1_valid <= issue;
            r_ocnt     <= n_ocnt;
            if (issue) begin
                r_idx <= last_item ? '0 : r_idx + IDX_W'(1);
            end
            if (r_s1_valid) begin
                r_owr <= ~r_owr;
            end
            if (pop_fire) begin
                r_ord <= ~r_ord;
            end
        end
    end

    // Payload registers of the read stage and the output queue.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1      <= s1_next;
            r_s1_zero <= zero_item;
        end
        if (r_s1_valid) begin
            r_out[r_owr] <= s2_item;
        end
    end

endmodule

[design/sync_len_cmd_crc8_deframer.sv]
// Path: the first result of a frame passes the descriptor queue, read stage and output
// queue after the CRC byte's transfer; later results follow one per cycle while pop is held.
// Throughput: one received byte per cycle. Input stalls (full) only while two finished
// frames wait in the descriptor queue, since the payload buffer holds two frames.
// Reset is synchronous, active low: parser, counters, queues and registers return to their
// reset values; the payload buffer is not cleared.
module sync_len_cmd_crc8_deframer #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_rx_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_frame_status,
    output logic [7:0]  o_command,
    output logic [5:0]  o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic [4:0]  o_byte_index,
    output logic        o_last,
    output logic [31:0] o_good_frame_count,
    output logic [31:0] o_crc_error_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import sldf_pkg::*;

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    t_cfg           r_cfg;
    logic           accept;
    logic           dq_full;
    logic           dq_empty;
    logic           dq_push;
    logic           dq_pop;
    t_desc          dq_in;
    t_desc          dq_head;
    logic           buf_we;
    logic [IDX_W:0] buf_waddr;
    logic [7:0]     buf_wdata;
    logic           buf_re;
    logic [IDX_W:0] buf_raddr;
    logic [7:0]     buf_rdata;
    t_result        result;

    assign o_full = dq_full;
    assign accept = i_push && !dq_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value     <= 8'd170;
            r_cfg.crc_polynomial <= 8'd7;
            r_cfg.crc_initial    <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_VALUE: r_cfg.sync_value     <= i_cfg_data;
                CFG_CRC_POLY:   r_cfg.crc_polynomial <= i_cfg_data;
                CFG_CRC_INIT:   r_cfg.crc_initial    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame parser.
    sldf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W),
        .LEN_W       (LEN_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_rx_byte),
        .i_cfg    (r_cfg),
        .o_push   (dq_push),
        .o_desc   (dq_in),
        .o_we     (buf_we),
        .o_waddr  (buf_waddr),
        .o_wdata  (buf_wdata)
    );

    // Two-frame payload buffer.
    sldf_pbuf #(
        .ADDR_W (IDX_W + 1)
    ) u_pbuf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // Queue of finished frames between parser and drain.
    sldf_dq u_dq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dq_push),
        .i_desc  (dq_in),
        .i_pop   (dq_pop),
        .o_head  (dq_head),
        .o_empty (dq_empty),
        .o_full  (dq_full)
    );

    // Result drain.
    sldf_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (dq_head),
        .i_desc_empty (dq_empty),
        .o_desc_pop   (dq_pop),
        .o_re         (buf_re),
        .o_raddr      (buf_raddr),
        .i_rdata      (buf_rdata),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_result     (result)
    );

    assign o_frame_status     = result.frame_status;
    assign o_command          = result.command;
    assign o_payload_length   = result.payload_length;
    assign o_payload_byte     = result.payload_byte;
    assign o_byte_index       = result.byte_index;
    assign o_last             = result.last;
    assign o_good_frame_count = result.good_frame_count;
    assign o_crc_error_count  = result.crc_error_count;

endmodule
